// ===== rtl/core/i2c_led_selector_register_file_defines.svh =====
`ifndef I2C_LED_SELECTOR_REGISTER_FILE_DEFINES_SVH
`define I2C_LED_SELECTOR_REGISTER_FILE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILSR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ilsr check failed");

// next-cycle implication, checked outside reset
`define ILSR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ilsr check failed");

`endif

// ===== rtl/core/ilsr_pkg.sv =====
`default_nettype none
package ilsr_pkg;

    localparam int NUM_PINS      = 16;
    localparam int LAST_REGISTER = 9;

    localparam logic [15:0] ACTIVE_MASK = 16'((32'd1 << NUM_PINS) - 32'd1);
    localparam logic [4:0]  REG_WRAP    = 5'(LAST_REGISTER + 1);

    localparam logic [7:0] NO_POINTER  = 8'hFF;
    localparam int         AUTOINC_BIT = 4;
    localparam logic [7:0] UNDEF_READ  = 8'hFF;

    localparam logic [3:0] REG_INPUT_LO    = 4'd0;
    localparam logic [3:0] REG_INPUT_HI    = 4'd1;
    localparam logic [3:0] REG_BLINK_FIRST = 4'd2;
    localparam logic [3:0] REG_BLINK_LAST  = 4'd5;
    localparam logic [3:0] REG_SEL_FIRST   = 4'd6;
    localparam logic [3:0] REG_SEL_LAST    = 4'd9;

    localparam logic [1:0] SEL_ON  = 2'd0;
    localparam logic [1:0] SEL_OFF = 2'd1;

    localparam logic [7:0] BLINK_RESET_PRESCALE = 8'hFF;
    localparam logic [7:0] BLINK_RESET_DUTY     = 8'h80;
    localparam logic [7:0] SEL_RESET            = 8'h55;
    localparam logic [15:0] LEVELS_RESET        = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_BUS_EVENT = 2'd0,
        OP_WRITE     = 2'd1,
        OP_READ      = 2'd2,
        OP_PIN       = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic [3:0] pin_index;
        logic       pin_level;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] pin_levels;
        logic [15:0] pin_edges;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/ilsr_in_reg.sv =====
`default_nettype none
module ilsr_in_reg
    import ilsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_ready,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/ilsr_regfile.sv =====
`default_nettype none
module ilsr_regfile
    import ilsr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_item i_item,
    input  wire logic  i_commit,
    output t_result    o_result
);

    logic [7:0]  r_ptr;
    logic        r_taken;
    logic [7:0]  r_blink [4];
    logic [7:0]  r_sel [4];
    logic [15:0] r_levels;
    logic [15:0] r_ext;

    logic [7:0]  n_ptr;
    logic        n_taken;
    logic [7:0]  n_blink [4];
    logic [7:0]  n_sel [4];
    logic [15:0] n_levels;
    logic [15:0] n_ext;

    logic [7:0]  rd;
    logic        refresh;
    logic        advance;
    logic [3:0]  idx;
    logic [3:0]  off_blink;
    logic [3:0]  off_sel;
    logic [4:0]  wrap_a;
    logic [4:0]  wrap_b;
    logic [4:0]  wrap_c;
    logic [15:0] fresh;

    assign idx       = r_ptr[3:0];
    assign off_blink = idx - REG_BLINK_FIRST;
    assign off_sel   = idx - REG_SEL_FIRST;

    // wrap after the last register
    assign wrap_a = {1'b0, idx} + 5'd1;
    assign wrap_b = (wrap_a >= REG_WRAP) ? (wrap_a - REG_WRAP) : wrap_a;
    assign wrap_c = (wrap_b >= REG_WRAP) ? (wrap_b - REG_WRAP) : wrap_b;

    always_comb begin
        n_ptr   = r_ptr;
        n_taken = r_taken;
        n_blink = r_blink;
        n_sel   = r_sel;
        n_ext   = r_ext;
        rd      = 8'd0;
        refresh = 1'b0;
        advance = 1'b0;
        unique case (i_item.op)
            OP_BUS_EVENT: begin
                n_taken = 1'b0;
            end
            OP_WRITE: begin
                if (!r_taken) begin
                    n_ptr   = i_item.data_byte;
                    n_taken = 1'b1;
                end else begin
                    if (idx >= REG_BLINK_FIRST && idx <= REG_BLINK_LAST) begin
                        n_blink[off_blink[1:0]] = i_item.data_byte;
                    end else if (idx >= REG_SEL_FIRST && idx <= REG_SEL_LAST) begin
                        n_sel[off_sel[1:0]] = i_item.data_byte;
                        refresh = 1'b1;
                    end
                    advance = 1'b1;
                end
            end
            OP_READ: begin
                priority if (idx == REG_INPUT_LO) begin
                    rd = r_levels[7:0];
                end else if (idx == REG_INPUT_HI) begin
                    rd = r_levels[15:8];
                end else if (idx >= REG_BLINK_FIRST && idx <= REG_BLINK_LAST) begin
                    rd = r_blink[off_blink[1:0]];
                end else if (idx >= REG_SEL_FIRST && idx <= REG_SEL_LAST) begin
                    rd = r_sel[off_sel[1:0]];
                end else begin
                    rd = UNDEF_READ;
                end
                advance = 1'b1;
            end
            OP_PIN: begin
                if ({1'b0, i_item.pin_index} < 5'(NUM_PINS)
                        && r_ext[i_item.pin_index] != i_item.pin_level) begin
                    n_ext[i_item.pin_index] = i_item.pin_level;
                    refresh = 1'b1;
                end
            end
            default: begin
                n_taken = r_taken;
            end
        endcase
        if (advance && r_ptr != NO_POINTER && r_ptr[AUTOINC_BIT]) begin
            n_ptr = {3'b000, 1'b1, wrap_c[3:0]};
        end
    end

    // per-pin level from its selector
    always_comb begin
        logic [1:0] sel;
        fresh = r_levels;
        for (int i = 0; i < 16; i++) begin
            sel = n_sel[i / 4][2 * (i % 4) +: 2];
            if (i < NUM_PINS) begin
                if (sel == SEL_ON) begin
                    fresh[i] = 1'b0;
                end else if (sel == SEL_OFF) begin
                    fresh[i] = n_ext[i];
                end
            end
        end
    end

    assign n_levels = refresh ? fresh : r_levels;

    assign o_result.read_data  = rd;
    assign o_result.pin_levels = n_levels;
    assign o_result.pin_edges  = (r_levels ^ n_levels) & ACTIVE_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= NO_POINTER;
            r_taken  <= 1'b0;
            r_blink  <= '{BLINK_RESET_PRESCALE, BLINK_RESET_DUTY,
                          BLINK_RESET_PRESCALE, BLINK_RESET_DUTY};
            r_sel    <= '{default: SEL_RESET};
            r_levels <= LEVELS_RESET;
            r_ext    <= LEVELS_RESET;
        end else if (i_commit) begin
            r_ptr    <= n_ptr;
            r_taken  <= n_taken;
            r_blink  <= n_blink;
            r_sel    <= n_sel;
            r_levels <= n_levels;
            r_ext    <= n_ext;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/i2c_led_selector_register_file.sv =====
// a request passes through the input register and then the output register before its result is valid
// throughput: one request per cycle, limited only by output backpressure
// each request is decoded combinationally and applied to the register state when it leaves the input register
// reset (synchronous, active low) restores the register file's registers to power-on values
// reset empties the input and output registers; no clearing pass is needed
`default_nettype none
`include "i2c_led_selector_register_file_defines.svh"
module i2c_led_selector_register_file
    import ilsr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [3:0]  i_pin_index,
    input  wire logic        i_pin_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_read_data,
    output logic [15:0]      o_pin_levels,
    output logic [15:0]      o_pin_edges
);

    t_item   in_item;
    t_item   cur_item;
    t_result cur_result;
    logic    cur_valid;
    logic    take;

    logic        r_out_valid;
    logic [7:0]  r_read_data;
    logic [15:0] r_pin_levels;
    logic [15:0] r_pin_edges;

    assign in_item.op        = t_op'(i_op);
    assign in_item.data_byte = i_data_byte;
    assign in_item.pin_index = i_pin_index;
    assign in_item.pin_level = i_pin_level;

    assign take = cur_valid && (!r_out_valid || i_out_ready);

    ilsr_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (in_item),
        .i_take  (take),
        .o_ready (o_in_ready),
        .o_valid (cur_valid),
        .o_item  (cur_item)
    );

    ilsr_regfile u_regfile (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (cur_item),
        .i_commit (take),
        .o_result (cur_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid <= cur_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_read_data  <= cur_result.read_data;
            r_pin_levels <= cur_result.pin_levels;
            r_pin_edges  <= cur_result.pin_edges;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_data  = r_read_data;
    assign o_pin_levels = r_pin_levels;
    assign o_pin_edges  = r_pin_edges;

    // a read never changes pin levels, so edges and read data exclude each other
    `ILSR_ASSERT_NOW(a_edges_no_read, i_clk, i_rst_n,
        o_out_valid && o_pin_edges != 16'd0, o_read_data == 8'd0)
    // pins beyond the active count are never flagged
    `ILSR_ASSERT_NOW(a_edges_active, i_clk, i_rst_n,
        o_out_valid, (o_pin_edges & ~ACTIVE_MASK) == 16'd0)
    // an empty input register always takes a request
    `ILSR_ASSERT_NOW(a_in_ready_empty, i_clk, i_rst_n,
        !cur_valid, o_in_ready)
    // a request taken from the input register always shows up at the output
    `ILSR_ASSERT_NEXT(a_take_out, i_clk, i_rst_n,
        take, o_out_valid)

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
module tb_top;
    import ilsr_pkg::*;

    localparam int TOTAL_REQUESTS = 1125;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AFTER     = 400;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_op         = '0;
    logic [7:0]  i_data_byte  = '0;
    logic [3:0]  i_pin_index  = '0;
    logic        i_pin_level  = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [7:0]  o_read_data;
    logic [15:0] o_pin_levels;
    logic [15:0] o_pin_edges;

    i2c_led_selector_register_file i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_data_byte  (i_data_byte),
        .i_pin_index  (i_pin_index),
        .i_pin_level  (i_pin_level),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_data  (o_read_data),
        .o_pin_levels (o_pin_levels),
        .o_pin_edges  (o_pin_edges)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    t_item   pending_requests [$];
    t_result expected_results [$];
    t_item   offered;
    int      n_requests = 0;
    int      n_results  = 0;
    int      n_errors   = 0;
    int      cycle_count = 0;

    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;

    // shadow copy of the register file
    logic [7:0]  ptr_state   = NO_POINTER;
    logic        addr_taken  = 1'b0;
    logic [7:0]  blink_state [4] = '{BLINK_RESET_PRESCALE, BLINK_RESET_DUTY,
                                     BLINK_RESET_PRESCALE, BLINK_RESET_DUTY};
    logic [7:0]  led_sel     [4] = '{SEL_RESET, SEL_RESET, SEL_RESET, SEL_RESET};
    logic [15:0] lvl_state   = LEVELS_RESET;
    logic [15:0] ext_shadow  = LEVELS_RESET;

    function automatic logic [15:0] refresh_levels();
        logic [15:0] prior;
        logic [1:0]  sel;
        prior = lvl_state;
        for (int i = 0; i < NUM_PINS; i++) begin
            sel = led_sel[i / 4][(i % 4) * 2 +: 2];
            if (sel == SEL_ON) begin
                lvl_state[i] = 1'b0;
            end else if (sel == SEL_OFF) begin
                lvl_state[i] = ext_shadow[i];
            end
        end
        return (prior ^ lvl_state) & ACTIVE_MASK;
    endfunction

    function automatic void advance_pointer_state();
        logic [4:0] nxt;
        if (ptr_state != NO_POINTER && ptr_state[AUTOINC_BIT]) begin
            nxt = (5'(ptr_state[3:0]) + 5'd1) % REG_WRAP;
            ptr_state = 8'(nxt[3:0]);
            ptr_state[AUTOINC_BIT] = 1'b1;
        end
    endfunction

    function automatic logic [7:0] register_value(logic [3:0] r);
        if (r == REG_INPUT_LO) return lvl_state[7:0];
        if (r == REG_INPUT_HI) return lvl_state[15:8];
        if (r >= REG_BLINK_FIRST && r <= REG_BLINK_LAST) return blink_state[r - REG_BLINK_FIRST];
        if (r >= REG_SEL_FIRST && r <= REG_SEL_LAST) return led_sel[r - REG_SEL_FIRST];
        return UNDEF_READ;
    endfunction

    function automatic t_result predict_led_request(t_item it);
        t_result    r;
        logic [3:0] reg_idx;
        r = '0;
        reg_idx = ptr_state[3:0];
        case (it.op)
            OP_BUS_EVENT: begin
                addr_taken = 1'b0;
            end
            OP_WRITE: begin
                if (!addr_taken) begin
                    ptr_state = it.data_byte;
                    addr_taken = 1'b1;
                end else begin
                    if (reg_idx >= REG_BLINK_FIRST && reg_idx <= REG_BLINK_LAST) begin
                        blink_state[reg_idx - REG_BLINK_FIRST] = it.data_byte;
                    end else if (reg_idx >= REG_SEL_FIRST && reg_idx <= REG_SEL_LAST) begin
                        led_sel[reg_idx - REG_SEL_FIRST] = it.data_byte;
                        r.pin_edges = refresh_levels();
                    end
                    advance_pointer_state();
                end
            end
            OP_READ: begin
                r.read_data = register_value(reg_idx);
                advance_pointer_state();
            end
            default: begin
                if (int'(it.pin_index) < NUM_PINS
                        && ext_shadow[it.pin_index] != it.pin_level) begin
                    ext_shadow[it.pin_index] = it.pin_level;
                    r.pin_edges = refresh_levels();
                end
            end
        endcase
        r.pin_levels = lvl_state;
        return r;
    endfunction

    // mostly short gaps, a few long ones, and stretches with none
    function automatic int pick_idle(int count);
        if ((count / 150) % 4 == 3) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 0;
            5, 6, 7: return $urandom_range(1, 3);
            8: return $urandom_range(4, 8);
            default: return $urandom_range(10, 40);
        endcase
    endfunction

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h55;
            2: return 8'hAA;
            3: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_pointer();
        logic [7:0] p;
        if ($urandom_range(0, 19) == 0) return NO_POINTER;
        p = 8'($urandom);
        if ($urandom_range(0, 3) != 0) p[7:5] = 3'b000;
        if ($urandom_range(0, 3) != 0) p[3:0] = 4'($urandom_range(0, LAST_REGISTER));
        return p;
    endfunction

    task automatic add_request(t_op op, logic [7:0] d, logic [3:0] p, logic l);
        t_item it;
        it.op = op;
        it.data_byte = d;
        it.pin_index = p;
        it.pin_level = l;
        pending_requests.push_back(it);
    endtask

    task automatic add_noisy(t_op op, logic [7:0] d);
        add_request(op, d, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : request_drive
        logic nxt_valid;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results.push_back(predict_led_request(offered));
                n_requests <= n_requests + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                nxt_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() != 0) begin
                    offered = pending_requests.pop_front();
                    nxt_valid = 1'b1;
                    gap_left = pick_idle(n_requests);
                end
                i_in_valid  <= nxt_valid;
                i_op        <= offered.op;
                i_data_byte <= offered.data_byte;
                i_pin_index <= offered.pin_index;
                i_pin_level <= offered.pin_level;
            end
        end
    end

    always @(posedge i_clk) begin : result_accept
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            // one long hold-off while requests keep coming
            if (!hold_done && n_requests >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = pick_idle(n_results);
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results <= n_results + 1;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, read_data %h pin_levels %h pin_edges %h",
                         $time, o_read_data, o_pin_levels, o_pin_edges);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_read_data !== want.read_data)
                    report_mismatch("read_data", 16'(want.read_data), 16'(o_read_data));
                if (o_pin_levels !== want.pin_levels)
                    report_mismatch("pin_levels", want.pin_levels, o_pin_levels);
                if (o_pin_edges !== want.pin_edges)
                    report_mismatch("pin_edges", want.pin_edges, o_pin_edges);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin : stimulus
        int kind;
        int len;
        int mode;
        t_op op;

        // read before any address phase, at the reset pointer
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);
        add_request(OP_BUS_EVENT, 8'h00, 4'd0, 1'b0);
        // auto-increment from the input registers into the blink settings
        add_request(OP_WRITE, 8'h10, 4'd0, 1'b0);
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'h00, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'hFF, 4'd0, 1'b0);
        add_request(OP_BUS_EVENT, 8'hFF, 4'hF, 1'b1);
        // every selector code, wrap back to the input register
        add_request(OP_WRITE, 8'h16, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'h00, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'hAA, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'hFF, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'h55, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'hAB, 4'd0, 1'b0);
        // pin reports: change, repeat, pin forced on
        add_request(OP_PIN, 8'h00, 4'd15, 1'b0);
        add_request(OP_PIN, 8'h00, 4'd15, 1'b0);
        add_request(OP_PIN, 8'h00, 4'd0, 1'b0);
        // the no-pointer value, which does not auto-increment, then auto-increment wrapping from the top register
        add_request(OP_BUS_EVENT, 8'h00, 4'd0, 1'b0);
        add_request(OP_WRITE, NO_POINTER, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'h12, 4'd0, 1'b0);
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);
        add_request(OP_BUS_EVENT, 8'h00, 4'd0, 1'b0);
        add_request(OP_WRITE, 8'h19, 4'd0, 1'b0);
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);
        add_request(OP_READ, 8'h00, 4'd0, 1'b0);

        while (pending_requests.size() < TOTAL_REQUESTS) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                add_noisy(OP_BUS_EVENT, 8'($urandom));
                add_noisy(OP_WRITE, random_pointer());
                len = $urandom_range(1, 8);
                mode = $urandom_range(0, 2);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 7) == 0) op = OP_PIN;
                    else if (mode == 0) op = OP_WRITE;
                    else if (mode == 1) op = OP_READ;
                    else op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
                    add_noisy(op, random_byte());
                end
            end else if (kind < 9) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) add_noisy(OP_PIN, 8'($urandom));
            end else begin
                len = $urandom_range(1, 4);
                for (int k = 0; k < len; k++) add_noisy(t_op'($urandom_range(0, 3)), 8'($urandom));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
